/* src/dcme_pkg.sv */
// ----------------------------------------------------------------------------
// dcme_pkg: shared constants and tables for the DCM to Euler angle block
// Holds the default sizes, the angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package dcme_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Guard shift applied to the vector before the micro-rotations.
  localparam int GUARD_SHIFT = 24;
  // Angle accumulator: Q28 radians in 32 bits.
  localparam int ANG_W    = 32;
  localparam int ANG_FRAC = 28;
  localparam int OUT_FRAC = 13;
  localparam int ANGLE_W  = 16;
  localparam int PITCH_W  = 15;
  localparam int TABLE_LEN = 24;

  localparam logic signed [ANG_W-1:0] PI_Q28 = 32'sd843314857;
  localparam logic signed [ANG_W-1:0] ROUND_HALF = 32'sd16384;
  localparam logic signed [ANG_W-1:0] PI_OUT = 32'sd25736;
  localparam logic signed [ANG_W-1:0] HALF_PI_OUT = 32'sd12868;

  // Rounded atan(2^-i) in Q28 radians.
  function automatic logic signed [ANG_W-1:0] atan_q28(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0: v = 32'sd210828714;
      1: v = 32'sd124459457;
      2: v = 32'sd65760959;
      3: v = 32'sd33381290;
      4: v = 32'sd16755422;
      5: v = 32'sd8385879;
      6: v = 32'sd4193963;
      7: v = 32'sd2097109;
      8: v = 32'sd1048571;
      9: v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* src/dcme_isqrt.sv */
// ----------------------------------------------------------------------------
// dcme_isqrt: pipelined integer square root
// Restoring digit recurrence, one root bit per register stage.
// ----------------------------------------------------------------------------
module dcme_isqrt #(
  parameter int ROOT_W = 15
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  localparam int REM_W = ROOT_W + 2;

  logic [2*ROOT_W-1:0] nsh [ROOT_W];
  logic [REM_W-1:0]    rem [ROOT_W];
  logic [ROOT_W-1:0]   rt  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [2*ROOT_W-1:0] n_in;
    logic [REM_W-1:0]    rem_in;
    logic [ROOT_W-1:0]   rt_in;
    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign n_in   = rad;
      assign rem_in = '0;
      assign rt_in  = '0;
    end else begin : g_next
      assign n_in   = nsh[k-1];
      assign rem_in = rem[k-1];
      assign rt_in  = rt[k-1];
    end

    assign rem_sh = {rem_in, n_in[2*ROOT_W-1 -: 2]};
    assign trial  = {2'b00, rt_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        nsh[k] <= {n_in[2*ROOT_W-3:0], 2'b00};
        rem[k] <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        rt[k]  <= {rt_in[ROOT_W-2:0], ge};
      end
    end
  end

  assign root = rt[ROOT_W-1];

endmodule

/* src/dcme_cordic.sv */
// ----------------------------------------------------------------------------
// dcme_cordic: pipelined vectoring CORDIC atan2
// One micro-rotation per stage; result in Q3.13 radians saturated to +-pi.
// ----------------------------------------------------------------------------
module dcme_cordic #(
  parameter int IN_W   = 16,
  parameter int STAGES = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [IN_W-1:0]       y,
  input  logic signed [IN_W-1:0]       x,
  output logic signed [dcme_pkg::ANGLE_W-1:0] angle
);
  import dcme_pkg::*;

  localparam int W = IN_W + GUARD_SHIFT + 3;

  logic signed [W-1:0]     xs [STAGES+1];
  logic signed [W-1:0]     ys [STAGES+1];
  logic signed [ANG_W-1:0] zz [STAGES+1];
  logic                    zf [STAGES+1];

  logic signed [W-1:0] x_ext, y_ext;
  assign x_ext = {{(W-IN_W){x[IN_W-1]}}, x} <<< GUARD_SHIFT;
  assign y_ext = {{(W-IN_W){y[IN_W-1]}}, y} <<< GUARD_SHIFT;

  // Vectors in the left half plane are turned by pi first.
  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x == '0) && (y == '0);
      if (x_ext < 0) begin
        zz[0] <= (y_ext >= 0) ? PI_Q28 : -PI_Q28;
        xs[0] <= -x_ext;
        ys[0] <= -y_ext;
      end else begin
        zz[0] <= '0;
        xs[0] <= x_ext;
        ys[0] <= y_ext;
      end
    end
  end

  for (genvar i = 1; i <= STAGES; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i] <= zf[i-1];
        if (ys[i-1] >= 0) begin
          xs[i] <= xs[i-1] + (ys[i-1] >>> (i-1));
          ys[i] <= ys[i-1] - (xs[i-1] >>> (i-1));
          zz[i] <= zz[i-1] + atan_q28(i-1);
        end else begin
          xs[i] <= xs[i-1] - (ys[i-1] >>> (i-1));
          ys[i] <= ys[i-1] + (xs[i-1] >>> (i-1));
          zz[i] <= zz[i-1] - atan_q28(i-1);
        end
      end
    end
  end

  logic signed [ANG_W-1:0] z_rnd;
  assign z_rnd = (zz[STAGES] + ROUND_HALF) >>> (ANG_FRAC - OUT_FRAC);

  always_ff @(posedge clk) begin
    if (en) begin
      if (zf[STAGES]) begin
        angle <= '0;
      end else if (z_rnd > PI_OUT) begin
        angle <= ANGLE_W'(PI_OUT);
      end else if (z_rnd < -PI_OUT) begin
        angle <= ANGLE_W'(-PI_OUT);
      end else begin
        angle <= z_rnd[ANGLE_W-1:0];
      end
    end
  end

endmodule

/* src/dcm_to_euler_angles.sv */
// ----------------------------------------------------------------------------
// dcm_to_euler_angles: Z-Y-X Euler angles from a direction cosine matrix
// Pipelined CORDIC extraction of yaw, pitch and roll, one matrix per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one matrix per beat: r00, r10, r20, r21 and r22,
// each SAMPLE_WIDTH bits of signed Q2.(SAMPLE_WIDTH-2), r00 in the lowest
// bits. The master stream returns one beat per matrix with yaw and roll in
// signed Q3.13 radians, pitch in signed Q2.13 radians, and a flag that pitch
// was clamped because |r20| exceeded one.
// From input beat to output beat a matrix passes two input stages,
// SAMPLE_WIDTH-1 square root stages, CORDIC_STAGES+2 CORDIC stages and
// the output register. Throughput is one beat per cycle while the output
// moves; every stage is a register and the three CORDIC pipelines run
// side by side.
// When the receiver stalls, the whole pipeline holds and one more input beat
// is taken into a skid register, after which s_tready drops until the
// output moves again. Synchronous reset clears all valid bits and the skid
// full flag; the data registers, skid data included, are not reset.
// ----------------------------------------------------------------------------
module dcm_to_euler_angles #(
  parameter int SAMPLE_WIDTH  = dcme_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = dcme_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0 up: dcm_r00, dcm_r10, dcm_r20, dcm_r21, dcm_r22,
  // zero pad to whole bytes.
  input  logic [((5*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // Fields from bit 0 up: yaw_angle[15:0], pitch_angle[30:16],
  // roll_angle[46:31], pitch_clamped[47].
  output logic [47:0] m_tdata
);
  import dcme_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int IN_W   = ((5*SAMPLE_WIDTH+7)/8)*8;
  localparam int ROOT_W = SW - 1;
  localparam int CD_LAT = CORDIC_STAGES + 2;
  localparam int VLD_N  = 2 + ROOT_W + CD_LAT;

  // The pipeline moves whenever the output register can take a beat.
  logic adv;
  assign adv = !m_tvalid || m_tready;

  // Skid register catches the beat offered while the pipeline holds.
  logic            skid_full;
  logic [IN_W-1:0] skid_data;
  logic [IN_W-1:0] in_data;

  assign s_tready = !skid_full;
  assign in_data  = skid_full ? skid_data : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (adv) begin
      skid_full <= 1'b0;
    end else if (s_tvalid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && s_tvalid && !skid_full) begin
      skid_data <= s_tdata;
    end
  end

  // Valid bits travel beside the data through every stage.
  logic [VLD_N-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[VLD_N-2:0], skid_full || s_tvalid};
      m_tvalid <= vld[VLD_N-1];
    end
  end

  // Stage A: register the samples.
  logic signed [SW-1:0] a_r00, a_r10, a_r20, a_r21, a_r22;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r00 <= in_data[0*SW +: SW];
      a_r10 <= in_data[1*SW +: SW];
      a_r20 <= in_data[2*SW +: SW];
      a_r21 <= in_data[3*SW +: SW];
      a_r22 <= in_data[4*SW +: SW];
    end
  end

  // Stage B: square r20 and decide the clamp against plus and minus one.
  localparam logic signed [SW-1:0] ONE = SW'(1) <<< (SW - 2);
  localparam logic [2*ROOT_W-1:0] ONE_SQ = (2*ROOT_W)'(1) << (2*SW - 4);

  logic signed [SW-1:0]   b_r00, b_r10, b_r20, b_r21, b_r22;
  logic signed [2*SW-1:0] b_sq;
  logic                   b_hi, b_lo;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r00 <= a_r00;
      b_r10 <= a_r10;
      b_r20 <= a_r20;
      b_r21 <= a_r21;
      b_r22 <= a_r22;
      b_sq  <= a_r20 * a_r20;
      b_hi  <= a_r20 > ONE;
      b_lo  <= a_r20 < -ONE;
    end
  end

  // Square root of 1 - r20^2 gives the cosine of pitch; a clamped beat
  // takes zero, its pitch is replaced at the output.
  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W-1:0]   root;

  assign rad = (b_hi || b_lo) ? '0 : ONE_SQ - b_sq[2*ROOT_W-1:0];

  dcme_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (rad),
    .root (root)
  );

  // Samples and clamp flags wait beside the square root.
  logic signed [SW-1:0] d_r00 [ROOT_W];
  logic signed [SW-1:0] d_r10 [ROOT_W];
  logic signed [SW-1:0] d_r20 [ROOT_W];
  logic signed [SW-1:0] d_r21 [ROOT_W];
  logic signed [SW-1:0] d_r22 [ROOT_W];
  logic                 d_hi  [ROOT_W];
  logic                 d_lo  [ROOT_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r00[0] <= b_r00;
      d_r10[0] <= b_r10;
      d_r20[0] <= b_r20;
      d_r21[0] <= b_r21;
      d_r22[0] <= b_r22;
      d_hi[0]  <= b_hi;
      d_lo[0]  <= b_lo;
      for (int k = 1; k < ROOT_W; k++) begin
        d_r00[k] <= d_r00[k-1];
        d_r10[k] <= d_r10[k-1];
        d_r20[k] <= d_r20[k-1];
        d_r21[k] <= d_r21[k-1];
        d_r22[k] <= d_r22[k-1];
        d_hi[k]  <= d_hi[k-1];
        d_lo[k]  <= d_lo[k-1];
      end
    end
  end

  // Three CORDIC pipelines: yaw, roll and the pitch arcsine.
  logic signed [ANGLE_W-1:0] yaw_a, roll_a, pitch_a;
  logic signed [SW-1:0]      cos_p;

  assign cos_p = {1'b0, root};

  dcme_cordic #(.IN_W(SW), .STAGES(CORDIC_STAGES)) u_yaw (
    .clk (clk), .en (adv),
    .y (d_r10[ROOT_W-1]), .x (d_r00[ROOT_W-1]), .angle (yaw_a)
  );

  dcme_cordic #(.IN_W(SW), .STAGES(CORDIC_STAGES)) u_roll (
    .clk (clk), .en (adv),
    .y (d_r21[ROOT_W-1]), .x (d_r22[ROOT_W-1]), .angle (roll_a)
  );

  dcme_cordic #(.IN_W(SW), .STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .en (adv),
    .y (d_r20[ROOT_W-1]), .x (cos_p), .angle (pitch_a)
  );

  logic c_hi [CD_LAT];
  logic c_lo [CD_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_hi[0] <= d_hi[ROOT_W-1];
      c_lo[0] <= d_lo[ROOT_W-1];
      for (int k = 1; k < CD_LAT; k++) begin
        c_hi[k] <= c_hi[k-1];
        c_lo[k] <= c_lo[k-1];
      end
    end
  end

  // Output: pitch is the negated arcsine, held to +-pi/2, or the clamp value.
  logic signed [ANGLE_W:0]   pitch_neg;
  logic signed [PITCH_W-1:0] pitch_sel;
  logic                      clamp_out;

  assign pitch_neg = -{pitch_a[ANGLE_W-1], pitch_a};
  assign clamp_out = c_hi[CD_LAT-1] || c_lo[CD_LAT-1];

  always_comb begin
    priority if (c_hi[CD_LAT-1]) begin
      pitch_sel = PITCH_W'(-HALF_PI_OUT);
    end else if (c_lo[CD_LAT-1]) begin
      pitch_sel = PITCH_W'(HALF_PI_OUT);
    end else if (pitch_neg > (ANGLE_W+1)'(HALF_PI_OUT)) begin
      pitch_sel = PITCH_W'(HALF_PI_OUT);
    end else if (pitch_neg < -(ANGLE_W+1)'(HALF_PI_OUT)) begin
      pitch_sel = PITCH_W'(-HALF_PI_OUT);
    end else begin
      pitch_sel = pitch_neg[PITCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {clamp_out, roll_a, pitch_sel, yaw_a};
    end
  end

  // Checks on the output values and the skid register.
  logic signed [PITCH_W-1:0] m_pitch;
  logic signed [ANGLE_W-1:0] m_yaw;
  assign m_pitch = m_tdata[30:16];
  assign m_yaw   = m_tdata[15:0];

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[47] |->
      (m_pitch == PITCH_W'(HALF_PI_OUT)) || (m_pitch == PITCH_W'(-HALF_PI_OUT)))
    else $error("clamped pitch is not plus or minus pi/2");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_yaw <= ANGLE_W'(PI_OUT)) && (m_yaw >= ANGLE_W'(-PI_OUT)))
    else $error("yaw outside plus or minus pi");

  a_skid_stall: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> $past(!adv))
    else $error("skid register filled while the pipeline was moving");

endmodule

/* tb/sv/tb_dcm_to_euler_angles.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dcm_to_euler_angles: self-checking bench for the DCM to Euler angle block
// Drives matrices over the slave stream with random gaps, predicts yaw, pitch,
// roll and the clamp flag in fixed point, and checks every output beat.
// ----------------------------------------------------------------------------
module tb_dcm_to_euler_angles;
  import dcme_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int IN_W = ((5 * SW + 7) / 8) * 8;
  localparam int LATENCY = SW + STAGES + 4;
  localparam longint ONE_Q14 = 64'sd1 << (SW - 2);

  typedef struct packed {
    logic signed [SW-1:0] r22;
    logic signed [SW-1:0] r21;
    logic signed [SW-1:0] r20;
    logic signed [SW-1:0] r10;
    logic signed [SW-1:0] r00;
  } matrix_t;

  typedef struct packed {
    logic clamped;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;

  matrix_t pending_matrices[$];
  euler_t expected_angles[$];
  int errors = 0;
  bit stimulus_done = 1'b0;
  int send_gap = 0;
  int stall_gap = 0;

  always #6 clk = ~clk;

  dcm_to_euler_angles uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Rounded atan(2^-i) in Q28 radians, kept locally for the predictor.
  function automatic longint atan_step(input int i);
    longint steps[24] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                          8385879, 4193963, 2097109, 1048571, 524287, 262144,
                          131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
                          512, 256, 128, 64, 32};
    return steps[i];
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Vectoring CORDIC; >>> on longint is a floor shift, as the hardware does.
  function automatic longint angle_of(input longint y, input longint x);
    longint z, xs, ys, t;
    z = 0;
    if (x == 0 && y == 0) return 0;
    xs = x <<< GUARD_SHIFT;
    ys = y <<< GUARD_SHIFT;
    if (xs < 0) begin
      z = (ys >= 0) ? 64'sd843314857 : -64'sd843314857;
      xs = -xs;
      ys = -ys;
    end
    for (int i = 0; i < STAGES && i < TABLE_LEN; i++) begin
      if (ys >= 0) begin
        t = xs + (ys >>> i);
        ys = ys - (xs >>> i);
        z += atan_step(i);
      end else begin
        t = xs - (ys >>> i);
        ys = ys + (xs >>> i);
        z -= atan_step(i);
      end
      xs = t;
    end
    z = (z + (64'sd1 <<< (ANG_FRAC - OUT_FRAC - 1))) >>> (ANG_FRAC - OUT_FRAC);
    return clip(z, 25736);
  endfunction

  function automatic longint root_floor(input longint n);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) begin
      r = r + 1;
    end
    return r;
  endfunction

  function automatic euler_t predict_angles(input matrix_t m);
    euler_t e;
    longint s, p;
    s = m.r20;
    e.yaw = 16'(angle_of(m.r10, m.r00));
    e.roll = 16'(angle_of(m.r21, m.r22));
    e.clamped = 1'b0;
    if (s > ONE_Q14) begin
      p = -12868;
      e.clamped = 1'b1;
    end else if (s < -ONE_Q14) begin
      p = 12868;
      e.clamped = 1'b1;
    end else begin
      p = clip(-angle_of(s, root_floor(ONE_Q14 * ONE_Q14 - s * s)), 12868);
    end
    e.pitch = 15'(p);
    return e;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic signed [SW-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return SW'($urandom);
      1: return SW'($urandom_range(0, 32767)) - 16'sd16384;
      2: return SW'(ONE_Q14 + $urandom_range(0, 2) - 1);
      3: return SW'(-ONE_Q14 + $urandom_range(0, 2) - 1);
      4: return SW'($urandom_range(0, 6) - 3);
      default: return SW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_matrix(input longint a, input longint b, input longint c,
                            input longint d, input longint f);
    matrix_t m;
    m.r00 = SW'(a);
    m.r10 = SW'(b);
    m.r20 = SW'(c);
    m.r21 = SW'(d);
    m.r22 = SW'(f);
    pending_matrices.push_back(m);
  endtask

  initial begin
    matrix_t m;
    // Directed: identity, zero vectors, the negative x axis, range extremes,
    // r20 at exactly plus and minus one and just beyond for the clamp.
    add_matrix(16384, 0, 0, 0, 16384);
    add_matrix(0, 0, 0, 0, 0);
    add_matrix(-16384, 0, 0, 0, -16384);
    add_matrix(-16384, -1, 0, -1, -16384);
    add_matrix(-32768, -32768, -32768, -32768, -32768);
    add_matrix(32767, 32767, 32767, 32767, 32767);
    add_matrix(0, 32767, 16384, 32767, 0);
    add_matrix(0, -32768, -16384, -32768, 0);
    add_matrix(1, 0, 16385, 0, 1);
    add_matrix(-1, 0, -16385, 0, -1);
    add_matrix(16384, 16384, 8192, -16384, 16384);
    add_matrix(-16384, 16384, -8192, 16384, -16384);
    add_matrix(0, 1, 1, -1, 0);
    add_matrix(32767, -32768, 16383, 0, -32768);
    add_matrix(-32768, 0, -16383, 0, 32767);
    add_matrix(1, 1, 11585, 1, 1);
    for (int n = 0; n < 1250; n++) begin
      m.r00 = rand_elem();
      m.r10 = rand_elem();
      m.r20 = rand_elem();
      m.r21 = rand_elem();
      m.r22 = rand_elem();
      pending_matrices.push_back(m);
    end
    stimulus_done = 1'b1;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver: holds a beat until it is taken, then optionally pauses.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_angles.push_back(predict_angles(matrix_t'(s_tdata[5*SW-1:0])));
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_matrices.size() > 0) begin
          s_tdata <= IN_W'(pending_matrices.pop_front());
          s_tvalid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compares each output beat field by field.
  always @(posedge clk) begin
    euler_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = euler_t'(m_tdata);
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_angles.pop_front();
          if (got.yaw !== want.yaw) begin
            $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
            errors++;
          end
          if (got.pitch !== want.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                     got.pitch);
            errors++;
          end
          if (got.roll !== want.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, want.roll,
                     got.roll);
            errors++;
          end
          if (got.clamped !== want.clamped) begin
            $display("%0t: clamp expected %0b actual %0b", $time, want.clamped,
                     got.clamped);
            errors++;
          end
        end
      end
      if (stall_gap > 0) begin
        stall_gap <= stall_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_gap <= pick_gap();
      end
    end
  end

  // Wait for the queue of pending beats to drain and every answer to arrive.
  // The queues are polled on the clock, since a wait on a queue size alone
  // is not woken by pushes and pops.
  initial begin
    wait (stimulus_done);
    @(posedge clk);
    while (rst || pending_matrices.size() != 0 || s_tvalid) begin
      @(posedge clk);
    end
    while (expected_angles.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
